FILE: design/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg: shared types and constants for the polyline ribbon mesher
// Coordinate formats, normal format, divider sizing and state encodings.
// ----------------------------------------------------------------------------
package prm_pkg;

  localparam int FRAC    = 16;            // fractional bits of coordinates
  localparam int CW      = 32;            // coordinate width
  localparam int NW      = FRAC + 2;      // signed normal component width
  localparam int QB      = NW;            // quotient bits per division
  localparam int DVW     = 31 + FRAC + 1; // dividend width
  localparam int DSW     = 32 + QB - 1;   // shifted divisor width
  localparam int DIV_CW  = $clog2(QB + 1);
  localparam int HW_W    = 31;            // half width register
  localparam int TOL_W   = 16;            // tolerance register
  localparam int MAGW    = NW - 1 + HW_W; // |n| * half_width
  localparam int OFFW    = MAGW - FRAC + 1;

  localparam logic CFG_HALF_WIDTH = 1'b0;
  localparam logic CFG_TOLERANCE  = 1'b1;

  localparam logic [HW_W-1:0]  HALF_WIDTH_RESET = HW_W'(65536);
  localparam logic [TOL_W-1:0] TOLERANCE_RESET  = TOL_W'(7);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } xy_t;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
  } norm_t;

  typedef enum logic [3:0] {
    N_IDLE, N_START, N_Z1, N_Z2, N_Z3, N_Z4, N_NORM, N_SQ1, N_SQ2, N_SQ3,
    N_SQRT, N_DVS, N_DIV, N_DONE
  } norm_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_END, S_MX, S_MY, S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    Q_STEP, Q_FINAL, Q_CLOSE
  } quad_kind_t;

  // Offset magnitude rounded half up, dropping FRAC bits.
  function automatic logic [OFFW-1:0] round_off(input logic [MAGW-1:0] mag);
    logic [MAGW:0] t;
    t = {1'b0, mag} + ((MAGW+1)'(1) << (FRAC - 1));
    return t[MAGW:FRAC];
  endfunction

  // Saturate a 35-bit signed sum to a coordinate.
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW+2:0] v);
    if (v > (CW+3)'(signed'(33'sh0_7FFF_FFFF)))
      return {1'b0, {(CW-1){1'b1}}};
    else if (v < -(CW+3)'(signed'(34'sh0_8000_0000)))
      return {1'b1, {(CW-1){1'b0}}};
    else
      return v[CW-1:0];
  endfunction

endpackage

FILE: design/prm_if.sv
// ----------------------------------------------------------------------------
// prm_point_if / prm_vertex_if: valid-ready channels of the mesher
// Input points and output vertices with source and sink views.
// ----------------------------------------------------------------------------
interface prm_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic        end_of_path;

  modport source (output valid, point_x, point_y, end_of_path, input ready);
  modport sink (input valid, point_x, point_y, end_of_path, output ready);
endinterface

interface prm_vertex_if;
  logic        valid;
  logic        ready;
  logic [31:0] vertex_x;
  logic [31:0] vertex_y;
  logic        run_end;

  modport source (output valid, vertex_x, vertex_y, run_end, input ready);
  modport sink (input valid, vertex_x, vertex_y, run_end, output ready);
endinterface

FILE: design/prm_normal.sv
// ----------------------------------------------------------------------------
// prm_normal: iterative unit left normal of one segment
// One shared multiplier, a bit-pair square root and a pair of restoring
// dividers step under a small sequencer.
// ----------------------------------------------------------------------------
module prm_normal (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  prm_pkg::xy_t              a,
  input  prm_pkg::xy_t              b,
  input  logic [prm_pkg::TOL_W-1:0] tol,
  output logic                      done,
  output prm_pkg::norm_t            n
);

  prm_pkg::norm_state_t state, state_next;

  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay, m;
  logic        sx, sy;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, acc, v, res, bitv;
  logic [63:0] sq_t;
  logic [prm_pkg::DVW-1:0] remx, remy;
  logic [prm_pkg::DSW-1:0] dsr;
  logic [prm_pkg::QB-1:0]  qx, qy;
  logic [prm_pkg::DIV_CW-1:0] cnt;
  logic in_tol_box;

  assign m          = (ax > ay) ? ax : ay;
  assign in_tol_box = (ax <= 33'(tol)) && (ay <= 33'(tol));
  assign sq_t       = res + bitv;

  always_comb begin
    mul_a = ax[31:0];
    mul_b = ax[31:0];
    case (state)
      prm_pkg::N_Z2, prm_pkg::N_SQ2: begin
        mul_a = ay[31:0];
        mul_b = ay[31:0];
      end
      prm_pkg::N_Z3: begin
        mul_a = 32'(tol);
        mul_b = 32'(tol);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prm_pkg::N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The magnitudes are registered in N_START, so the tolerance box is
  // tested in the following state, N_Z1.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      prm_pkg::N_IDLE:  if (start) state_next = prm_pkg::N_START;
      prm_pkg::N_START: state_next = prm_pkg::N_Z1;
      prm_pkg::N_Z1:    state_next = in_tol_box ? prm_pkg::N_Z2 : prm_pkg::N_NORM;
      prm_pkg::N_Z2:    state_next = prm_pkg::N_Z3;
      prm_pkg::N_Z3:    state_next = prm_pkg::N_Z4;
      prm_pkg::N_Z4:    state_next = (acc <= prod) ? prm_pkg::N_DONE : prm_pkg::N_NORM;
      prm_pkg::N_NORM: begin
        if (m < 33'h0_8000_0000 && m >= 33'h0_4000_0000) state_next = prm_pkg::N_SQ1;
      end
      prm_pkg::N_SQ1:   state_next = prm_pkg::N_SQ2;
      prm_pkg::N_SQ2:   state_next = prm_pkg::N_SQ3;
      prm_pkg::N_SQ3:   state_next = prm_pkg::N_SQRT;
      prm_pkg::N_SQRT:  if (bitv == 64'd1) state_next = prm_pkg::N_DVS;
      prm_pkg::N_DVS:   state_next = prm_pkg::N_DIV;
      prm_pkg::N_DIV:   if (cnt == prm_pkg::DIV_CW'(prm_pkg::QB - 1)) state_next = prm_pkg::N_DONE;
      prm_pkg::N_DONE: begin
        done       = 1'b1;
        state_next = prm_pkg::N_IDLE;
      end
      default: state_next = prm_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    case (state)
      prm_pkg::N_IDLE: begin
        if (start) begin
          dx <= 33'(a.y) - 33'(b.y);
          dy <= 33'(b.x) - 33'(a.x);
        end
      end
      prm_pkg::N_START: begin
        sx <= dx[32];
        sy <= dy[32];
        ax <= dx[32] ? 33'(-dx) : 33'(dx);
        ay <= dy[32] ? 33'(-dy) : 33'(dy);
      end
      prm_pkg::N_Z2: acc <= prod;
      prm_pkg::N_Z3: acc <= acc + prod;
      prm_pkg::N_Z4: begin
        qx <= '0;
        qy <= '0;
      end
      prm_pkg::N_NORM: begin
        // Bring the larger magnitude into [2^30, 2^31).
        if (m >= 33'h0_8000_0000) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
        end else if (m < 33'h0_0800_0000) begin
          ax <= ax << 4;
          ay <= ay << 4;
        end else if (m < 33'h0_4000_0000) begin
          ax <= ax << 1;
          ay <= ay << 1;
        end
      end
      prm_pkg::N_SQ2: acc <= prod;
      prm_pkg::N_SQ3: begin
        v    <= acc + prod;
        res  <= '0;
        bitv <= 64'd1 << 62;
      end
      prm_pkg::N_SQRT: begin
        if (v >= sq_t) begin
          v   <= v - sq_t;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      prm_pkg::N_DVS: begin
        remx <= (prm_pkg::DVW'(ax[30:0]) << prm_pkg::FRAC) + prm_pkg::DVW'(res[31:1]);
        remy <= (prm_pkg::DVW'(ay[30:0]) << prm_pkg::FRAC) + prm_pkg::DVW'(res[31:1]);
        dsr  <= prm_pkg::DSW'(res[31:0]) << (prm_pkg::QB - 1);
        cnt  <= '0;
        qx   <= '0;
        qy   <= '0;
      end
      prm_pkg::N_DIV: begin
        if (prm_pkg::DSW'(remx) >= dsr) begin
          remx <= remx - prm_pkg::DVW'(dsr);
          qx   <= {qx[prm_pkg::QB-2:0], 1'b1};
        end else begin
          qx <= {qx[prm_pkg::QB-2:0], 1'b0};
        end
        if (prm_pkg::DSW'(remy) >= dsr) begin
          remy <= remy - prm_pkg::DVW'(dsr);
          qy   <= {qy[prm_pkg::QB-2:0], 1'b1};
        end else begin
          qy <= {qy[prm_pkg::QB-2:0], 1'b0};
        end
        dsr <= dsr >> 1;
        cnt <= cnt + prm_pkg::DIV_CW'(1);
      end
      default: ;
    endcase
  end

  assign n.x = sx ? -$signed(qx) : $signed(qx);
  assign n.y = sy ? -$signed(qy) : $signed(qy);

endmodule

FILE: design/polyline_ribbon_mesher.sv
// ----------------------------------------------------------------------------
// polyline_ribbon_mesher: triangle ribbon of a closed polyline
// Work: a point that starts a new segment waits for its normal (normalize,
// 32-step square root, 18-step paired division). Each emitted vertex then
// passes S_MX and S_MY on the shared offset multiplier and then S_OUT,
// which stalls while the output register is full.
// One point is in work at a time; ready is high only in the idle state.
// Reset (rst, synchronous) clears path state, the sequencer and the output
// register, and loads half_width = 1.0 and tolerance = 7.
// ----------------------------------------------------------------------------
module polyline_ribbon_mesher (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [prm_pkg::HW_W-1:0] cfg_data,
  prm_point_if.sink                pt,
  prm_vertex_if.source             vtx
);

  // Configuration registers.
  logic [prm_pkg::HW_W-1:0]  half_width;
  logic [prm_pkg::TOL_W-1:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= prm_pkg::HALF_WIDTH_RESET;
      tolerance  <= prm_pkg::TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        prm_pkg::CFG_HALF_WIDTH: half_width <= cfg_data;
        prm_pkg::CFG_TOLERANCE:  tolerance  <= cfg_data[prm_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Path state: the last raw point, the first kept point, the two most
  // recent kept points and their normals.
  prm_pkg::seq_state_t state, state_next;
  prm_pkg::quad_kind_t kind;
  logic          raw_prev_valid;
  prm_pkg::xy_t  raw_prev_xy, first_xy, kept_prev_xy, kept_older_xy, cur_xy;
  prm_pkg::norm_t first_normal, prev_normal;
  logic [1:0]    kept_count;
  logic          eop;

  // The quad in flight and the vertex index inside it.
  prm_pkg::xy_t   qa, qb;
  prm_pkg::norm_t qna, qnb;
  logic [2:0]     vidx;

  prm_pkg::xy_t   in_xy;
  logic signed [32:0] ddx, ddy;
  logic [32:0]  ux, uy;
  logic         keep, accept;

  logic           norm_start, norm_done;
  prm_pkg::norm_t norm_n;

  assign in_xy.x = signed'(pt.point_x);
  assign in_xy.y = signed'(pt.point_y);
  assign ddx     = 33'(in_xy.x) - 33'(raw_prev_xy.x);
  assign ddy     = 33'(in_xy.y) - 33'(raw_prev_xy.y);
  assign ux      = ddx[32] ? 33'(-ddx) : 33'(ddx);
  assign uy      = ddy[32] ? 33'(-ddy) : 33'(ddy);
  // A point strictly inside the tolerance box of the previous raw point
  // is dropped; the first point of a path is always kept.
  assign keep    = !raw_prev_valid || !(ux < 33'(tolerance) && uy < 33'(tolerance));

  assign pt.ready   = (state == prm_pkg::S_IDLE);
  assign accept     = pt.valid && pt.ready;
  assign norm_start = accept && keep && (kept_count != 2'd0);

  prm_normal u_normal (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .a     (kept_prev_xy),
    .b     (in_xy),
    .tol   (tolerance),
    .done  (norm_done),
    .n     (norm_n)
  );

  // Vertex order in a quad: A-, A+, B+, B+, B-, A-.
  logic           use_a, plus;
  prm_pkg::xy_t   vp;
  prm_pkg::norm_t vn;
  logic [prm_pkg::NW-2:0]   mul_c;
  logic [prm_pkg::MAGW-1:0] prod;
  logic [prm_pkg::OFFW-1:0] offx_mag, offy_mag;
  logic signed [prm_pkg::CW+2:0] offx, offy, sumx, sumy;
  logic out_free, quad_last, last_vertex;

  assign use_a = (vidx == 3'd0) || (vidx == 3'd1) || (vidx == 3'd5);
  assign plus  = (vidx == 3'd1) || (vidx == 3'd2) || (vidx == 3'd3);
  assign vp    = use_a ? qa : qb;
  assign vn    = use_a ? qna : qnb;

  // The shared offset multiplier takes |n.x| then |n.y|.
  always_comb begin
    if (state == prm_pkg::S_MY)
      mul_c = vn.y[prm_pkg::NW-1] ? (prm_pkg::NW-1)'(-vn.y) : vn.y[prm_pkg::NW-2:0];
    else
      mul_c = vn.x[prm_pkg::NW-1] ? (prm_pkg::NW-1)'(-vn.x) : vn.x[prm_pkg::NW-2:0];
  end

  assign offy_mag = prm_pkg::round_off(prod);
  assign offx = vn.x[prm_pkg::NW-1] ? -(prm_pkg::CW+3)'(offx_mag) : (prm_pkg::CW+3)'(offx_mag);
  assign offy = vn.y[prm_pkg::NW-1] ? -(prm_pkg::CW+3)'(offy_mag) : (prm_pkg::CW+3)'(offy_mag);
  assign sumx = plus ? (prm_pkg::CW+3)'(vp.x) + offx : (prm_pkg::CW+3)'(vp.x) - offx;
  assign sumy = plus ? (prm_pkg::CW+3)'(vp.y) + offy : (prm_pkg::CW+3)'(vp.y) - offy;

  assign out_free  = !vtx.valid || vtx.ready;
  assign quad_last = (vidx == 3'd5);
  // The step quad ends the run unless the point also closes the path.
  assign last_vertex = quad_last &&
                       (kind == prm_pkg::Q_CLOSE || (kind == prm_pkg::Q_STEP && !eop));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      prm_pkg::S_IDLE: begin
        if (accept) begin
          if (keep && kept_count != 2'd0) state_next = prm_pkg::S_NORM;
          else state_next = prm_pkg::S_END;
        end
      end
      prm_pkg::S_NORM: begin
        if (norm_done) state_next = (kept_count == 2'd1) ? prm_pkg::S_END : prm_pkg::S_MX;
      end
      prm_pkg::S_END: begin
        state_next = (eop && kept_count[1]) ? prm_pkg::S_MX : prm_pkg::S_IDLE;
      end
      prm_pkg::S_MX: state_next = prm_pkg::S_MY;
      prm_pkg::S_MY: state_next = prm_pkg::S_OUT;
      prm_pkg::S_OUT: begin
        if (out_free) begin
          if (!quad_last) state_next = prm_pkg::S_MX;
          else if (kind == prm_pkg::Q_STEP) state_next = prm_pkg::S_END;
          else if (kind == prm_pkg::Q_FINAL) state_next = prm_pkg::S_MX;
          else state_next = prm_pkg::S_IDLE;
        end
      end
      default: state_next = prm_pkg::S_IDLE;
    endcase
  end

  // Control part of the path state.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev_valid <= 1'b0;
      kept_count     <= 2'd0;
      vtx.valid      <= 1'b0;
    end else begin
      // A new vertex loads the output register; otherwise a taken one clears it.
      if (state == prm_pkg::S_OUT && out_free) vtx.valid <= 1'b1;
      else if (vtx.ready) vtx.valid <= 1'b0;
      case (state)
        prm_pkg::S_IDLE: begin
          if (accept) begin
            raw_prev_valid <= 1'b1;
            if (keep && kept_count == 2'd0) kept_count <= 2'd1;
          end
        end
        prm_pkg::S_NORM: begin
          if (norm_done) kept_count <= (kept_count == 2'd1) ? 2'd2 : 2'd3;
        end
        prm_pkg::S_END: begin
          if (eop && !kept_count[1]) begin
            raw_prev_valid <= 1'b0;
            kept_count     <= 2'd0;
          end
        end
        prm_pkg::S_OUT: begin
          if (out_free && quad_last && kind == prm_pkg::Q_CLOSE) begin
            raw_prev_valid <= 1'b0;
            kept_count     <= 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload part: points, normals, the quad in flight and the output.
  always_ff @(posedge clk) begin
    case (state)
      prm_pkg::S_IDLE: begin
        if (accept) begin
          cur_xy      <= in_xy;
          eop         <= pt.end_of_path;
          raw_prev_xy <= in_xy;
          if (keep && kept_count == 2'd0) begin
            first_xy     <= in_xy;
            kept_prev_xy <= in_xy;
          end
        end
      end
      prm_pkg::S_NORM: begin
        if (norm_done) begin
          // The step quad uses the older state; it is captured before the
          // path state moves on.
          qa   <= kept_older_xy;
          qna  <= prev_normal;
          qb   <= kept_prev_xy;
          qnb  <= norm_n;
          kind <= prm_pkg::Q_STEP;
          vidx <= 3'd0;
          if (kept_count == 2'd1) first_normal <= norm_n;
          prev_normal   <= norm_n;
          kept_older_xy <= kept_prev_xy;
          kept_prev_xy  <= cur_xy;
        end
      end
      prm_pkg::S_END: begin
        qa   <= kept_older_xy;
        qna  <= prev_normal;
        qb   <= kept_prev_xy;
        qnb  <= prev_normal;
        kind <= prm_pkg::Q_FINAL;
        vidx <= 3'd0;
      end
      prm_pkg::S_MX: prod <= prm_pkg::MAGW'(mul_c) * prm_pkg::MAGW'(half_width);
      prm_pkg::S_MY: begin
        offx_mag <= prm_pkg::round_off(prod);
        prod     <= prm_pkg::MAGW'(mul_c) * prm_pkg::MAGW'(half_width);
      end
      prm_pkg::S_OUT: begin
        if (out_free) begin
          vtx.vertex_x <= prm_pkg::sat_coord(sumx);
          vtx.vertex_y <= prm_pkg::sat_coord(sumy);
          vtx.run_end  <= last_vertex;
          vidx         <= quad_last ? 3'd0 : vidx + 3'd1;
          if (quad_last && kind == prm_pkg::Q_FINAL) begin
            // The closing quad runs from the last kept point back to the first.
            qa   <= kept_prev_xy;
            qna  <= prev_normal;
            qb   <= first_xy;
            qnb  <= first_normal;
            kind <= prm_pkg::Q_CLOSE;
          end
        end
      end
      default: ;
    endcase
  end

  // A raw point is remembered exactly while some point of the path is kept.
  a_raw_vs_kept: assert property (@(posedge clk) disable iff (rst)
    raw_prev_valid == (kept_count != 2'd0))
    else $error("raw point valid disagrees with kept count");

  // The normal unit reports only while the sequencer waits for it.
  a_norm_done_wait: assert property (@(posedge clk) disable iff (rst)
    norm_done |-> state == prm_pkg::S_NORM)
    else $error("normal finished outside of the wait state");

  // A step quad is only built once three points are on record.
  a_step_quad_count: assert property (@(posedge clk) disable iff (rst)
    (state == prm_pkg::S_MX && kind == prm_pkg::Q_STEP) |-> kept_count == 2'd3)
    else $error("step quad emitted with too few kept points");

  // Starting a normal moves the sequencer into the wait state.
  a_norm_start_idle: assert property (@(posedge clk) disable iff (rst)
    norm_start |=> state == prm_pkg::S_NORM)
    else $error("normal started without entering the wait state");

endmodule
